### rtl/kcwc_pkg.sv
// ----------------------------------------------------------------------------
// kcwc_pkg: shared types, constants and form table for the keyword counter
// Holds the item structs, the Windows-1251 letter test and the table of
// 45 lowercase word forms with their lengths and classes.
// ----------------------------------------------------------------------------
package kcwc_pkg;

   localparam int MAX_WORD_LEN = 16;
   localparam int NUM_STEMS    = 45;
   localparam int NUM_FORMS    = 2 * NUM_STEMS;
   localparam int NUM_CLASSES  = 12;
   localparam int STEM_CHARS   = 9;
   localparam int POS_W        = $clog2(MAX_WORD_LEN + 1);
   localparam int LEN_W        = $clog2(STEM_CHARS + 1);
   localparam int CLASS_W      = 4;
   localparam int COUNT_W      = 32;

   localparam logic [CLASS_W-1:0] LAST_CLASS = CLASS_W'(NUM_CLASSES - 1);

   // Byte codes that count as letters besides the 0xC0..0xFF block
   localparam logic [7:0] BYTE_HYPHEN     = 8'h2D;
   localparam logic [7:0] BYTE_CAP_YO     = 8'hA8;
   localparam logic [7:0] BYTE_SMALL_YO   = 8'hB8;
   localparam logic [7:0] BYTE_CYR_FIRST  = 8'hC0;
   localparam logic [7:0] CAPITAL_OFFSET  = 8'h20;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [CLASS_W-1:0] word_class;
      logic [COUNT_W-1:0] class_count;
      logic               last_class;
   } rsp_type;

   // Word-close event handed from the matcher to the counter cells
   typedef struct packed {
      logic [NUM_CLASSES-1:0] class_hit;
      logic                   eot;
   } event_type;

   // Per-cell control
   typedef struct packed {
      logic hit;
      logic load;
      logic shift;
   } cell_ctl_type;

   // Lowercase forms, first letter in the top byte, zero padded
   localparam logic [8*STEM_CHARS-1:0] STEM_TEXT [NUM_STEMS] = '{
      72'hF7F2EE_000000_000000, // chto
      72'hF7E5E3_EE0000_000000,
      72'hF7E5EC_F30000_000000,
      72'hF7E5EC_000000_000000,
      72'hF7B8EC_000000_000000,
      72'hEAF2EE_000000_000000, // kto
      72'hEAEEEC_F30000_000000,
      72'hEAEEE3_EE0000_000000,
      72'hEAE5EC_000000_000000,
      72'hEAEEEC_000000_000000,
      72'hF1EAEE_EBFCEA_EE0000, // skolko
      72'hF1EAEE_EBFCEA_E8F500,
      72'hF1EAEE_EBFCEA_E8EC00,
      72'hF1EAEE_EBFCEA_E8ECE8,
      72'hEAEEF2_EEF0FB_E90000, // kotoryj
      72'hEAEEF2_EEF0EE_E50000,
      72'hEAEEF2_EEF0E0_FF0000,
      72'hEAEEF2_EEF0FB_E50000,
      72'hEAEEF2_EEF0EE_E3EE00,
      72'hEAEEF2_EEF0EE_E90000,
      72'hEAEEF2_EEF0FB_F50000,
      72'hEAEEF2_EEF0EE_ECF300,
      72'hEAEEF2_EEF0FB_EC0000,
      72'hEAEEF2_EEF0EE_FE0000,
      72'hEAEEF2_EEF0FB_ECE800,
      72'hEAEEF2_EEF0EE_EC0000,
      72'hEAE0EA_EEE900_000000, // kakoj
      72'hEAE0EA_EEE500_000000,
      72'hEAE0EA_E0FF00_000000,
      72'hEAE0EA_E8E500_000000,
      72'hEAE0EA_EEE3EE_000000,
      72'hEAE0EA_E8F500_000000,
      72'hEAE0EA_EEECF3_000000,
      72'hEAE0EA_E8EC00_000000,
      72'hEAE0EA_F3FE00_000000,
      72'hEAE0EA_EEFE00_000000,
      72'hEAE0EA_E8ECE8_000000,
      72'hEAE0EA_EEEC00_000000,
      72'hEAE0EA_000000_000000, // kak
      72'hE3E4E5_000000_000000, // gde
      72'hE7E0F7_E5EC00_000000, // zachem
      72'hEAEEE3_E4E000_000000, // kogda
      72'hEFEEF7_E5ECF3_000000, // pochemu
      72'hEAF3E4_E00000_000000, // kuda
      72'hEEF2EA_F3E4E0_000000  // otkuda
   };

   localparam logic [LEN_W-1:0] STEM_LEN [NUM_STEMS] = '{
      4'd3, 4'd4, 4'd4, 4'd3, 4'd3,
      4'd3, 4'd4, 4'd4, 4'd3, 4'd3,
      4'd7, 4'd8, 4'd8, 4'd9,
      4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd7, 4'd7, 4'd8, 4'd7, 4'd7, 4'd8, 4'd7,
      4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd5, 4'd5, 4'd6, 4'd5,
      4'd3, 4'd3, 4'd5, 4'd5, 4'd6, 4'd4, 4'd6
   };

   localparam logic [CLASS_W-1:0] STEM_CLASS [NUM_STEMS] = '{
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd2, 4'd2, 4'd2, 4'd2,
      4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
      4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
      4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11
   };

   function automatic logic is_letter(input logic [7:0] b);
      return (b == BYTE_HYPHEN) || (b == BYTE_CAP_YO) || (b == BYTE_SMALL_YO) ||
             (b >= BYTE_CYR_FIRST);
   endfunction

   // Letter of stem k at position pos; zero past the table width
   function automatic logic [7:0] stem_char(input int k, input logic [POS_W-1:0] pos);
      logic [7:0] c;
      c = '0;
      for (int j = 0; j < STEM_CHARS; j++) begin
         if (pos == POS_W'(j)) c = STEM_TEXT[k][8*(STEM_CHARS-j)-1 -: 8];
      end
      return c;
   endfunction

endpackage

### rtl/kcwc_matcher.sv
// ----------------------------------------------------------------------------
// kcwc_matcher: whole-word match against the form table
// Tracks the open word with one still-matching bit per form and emits a
// registered close event carrying the class hit vector and end-of-text.
// ----------------------------------------------------------------------------
module kcwc_matcher
   import kcwc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req,
   output event_type event_out
);

   logic [NUM_FORMS-1:0]   match_ff, match_in, match_upd;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic                   inside_ff, inside_in;
   event_type              event_ff, event_in;
   logic [NUM_CLASSES-1:0] hit_vec;
   logic                   letter;

   assign letter = is_letter(req.text_byte) && !req.end_of_text;

   // Advance every form on the new letter; collect hits of a closing word
   always_comb begin
      logic [7:0] c;
      logic       ok;
      hit_vec   = '0;
      match_upd = '0;
      for (int k = 0; k < NUM_STEMS; k++) begin
         for (int v = 0; v < 2; v++) begin
            if (match_ff[2*k+v] && (POS_W'(STEM_LEN[k]) == pos_ff))
               hit_vec[STEM_CLASS[k]] = 1'b1;
            c = stem_char(k, pos_ff);
            if ((v == 1) && (pos_ff == '0)) c = c - CAPITAL_OFFSET;
            ok = (pos_ff < POS_W'(STEM_LEN[k])) && (c == req.text_byte);
            match_upd[2*k+v] = match_ff[2*k+v] && ok;
         end
      end
   end

   // Next word state and close event
   always_comb begin
      match_in  = match_ff;
      pos_in    = pos_ff;
      inside_in = inside_ff;
      event_in  = '0;
      if (accept) begin
         if (letter) begin
            match_in  = match_upd;
            inside_in = 1'b1;
            if (pos_ff < POS_W'(MAX_WORD_LEN)) pos_in = pos_ff + POS_W'(1);
         end else begin
            match_in           = '1;
            pos_in             = '0;
            inside_in          = 1'b0;
            event_in.class_hit = inside_ff ? hit_vec : '0;
            event_in.eot       = req.end_of_text;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff  <= '1;
         pos_ff    <= '0;
         inside_ff <= 1'b0;
         event_ff  <= '0;
      end else begin
         match_ff  <= match_in;
         pos_ff    <= pos_in;
         inside_ff <= inside_in;
         event_ff  <= event_in;
      end
   end

   assign event_out = event_ff;

endmodule

### rtl/kcwc_cell.sv
// ----------------------------------------------------------------------------
// kcwc_cell: one class counter with its slot in the drain chain
// Counts hits for its class, saturating. On end-of-text it drops its count
// into its slot and clears; slots then shift toward the output.
// ----------------------------------------------------------------------------
module kcwc_cell
   import kcwc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [CLASS_W-1:0] cell_index,
   input  cell_ctl_type       ctl,
   input  rsp_type            slot_next,
   input  logic               slot_next_valid,
   output rsp_type            slot,
   output logic               slot_valid
);

   logic [COUNT_W-1:0] count_ff, count_in, count_upd;
   rsp_type            slot_ff, slot_in;
   logic               slot_valid_ff, slot_valid_in;

   // Saturating increment
   assign count_upd = (ctl.hit && (count_ff != '1)) ? count_ff + COUNT_W'(1) : count_ff;

   // Load on end-of-text, shift when the head item leaves, else hold
   always_comb begin
      count_in      = count_upd;
      slot_in       = slot_ff;
      slot_valid_in = slot_valid_ff;
      if (ctl.load) begin
         count_in            = '0;
         slot_in.word_class  = cell_index;
         slot_in.class_count = count_upd;
         slot_in.last_class  = (cell_index == LAST_CLASS);
         slot_valid_in       = 1'b1;
      end else if (ctl.shift) begin
         slot_in       = slot_next;
         slot_valid_in = slot_next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         slot_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot       = slot_ff;
   assign slot_valid = slot_valid_ff;

endmodule

### rtl/keyword_class_word_counter.sv
// ----------------------------------------------------------------------------
// keyword_class_word_counter: whole-word question-word counter
// Counts Windows-1251 words that equal one of 90 fixed forms, each tied to
// a class, and reports the 12 class counts on each end-of-text mark.
// ----------------------------------------------------------------------------
//  channel | dir | ports                          | item
//  req     | in  | req_valid req_stall req_payload | text_byte, end_of_text
//  rsp     | out | rsp_valid rsp_stall rsp_payload | word_class, class_count, last_class
//
//  A text byte is taken every cycle; the word state is registered, and a
//  closed word reaches the counters through the registered close event.
//  An end-of-text mark loads all 12 counts into the cell chain, which sends
//  one result per cycle while rsp_stall is low; a further end-of-text mark
//  waits until the chain is empty, text bytes keep flowing meanwhile.
//  Synchronous reset clears the counters, the word state and the chain.
//  rsp_stall holds the head result in its register; it never blocks text.
// ----------------------------------------------------------------------------
module keyword_class_word_counter
   import kcwc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   event_type    event_q;
   cell_ctl_type cell_ctl   [NUM_CLASSES];
   rsp_type      slot       [NUM_CLASSES+1];
   logic         slot_valid [NUM_CLASSES+1];
   logic         req_accept;
   logic         rsp_fire;

   // Hold an end-of-text item while the chain still drains or loads
   assign req_stall  = req_payload.end_of_text && (slot_valid[0] || event_q.eot);
   assign req_accept = req_valid && !req_stall;
   assign rsp_fire   = rsp_valid && !rsp_stall;

   kcwc_matcher u_matcher (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .req       (req_payload),
      .event_out (event_q)
   );

   // Chain tail feeds nothing
   assign slot[NUM_CLASSES]       = '0;
   assign slot_valid[NUM_CLASSES] = 1'b0;

   for (genvar gi = 0; gi < NUM_CLASSES; gi++) begin : g_cell
      assign cell_ctl[gi] = '{hit: event_q.class_hit[gi], load: event_q.eot, shift: rsp_fire};

      kcwc_cell u_cell (
         .clock           (clock),
         .reset           (reset),
         .cell_index      (CLASS_W'(gi)),
         .ctl             (cell_ctl[gi]),
         .slot_next       (slot[gi+1]),
         .slot_next_valid (slot_valid[gi+1]),
         .slot            (slot[gi]),
         .slot_valid      (slot_valid[gi])
      );
   end

   assign rsp_valid   = slot_valid[0];
   assign rsp_payload = slot[0];

endmodule

### rtl/kcwc_checker.sv
// ----------------------------------------------------------------------------
// kcwc_checker: port-level checks for the keyword counter
// Watches the result sequence and end-of-text flow control over time.
// ----------------------------------------------------------------------------
module kcwc_checker
   import kcwc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // Results run back to back in class order until the last one
   a_rsp_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last_class |=>
         rsp_valid && (rsp_payload.word_class == $past(rsp_payload.word_class) + 4'd1))
      else $error("result sequence broken");

   // Only the final class carries the last mark
   a_last_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_class |-> rsp_payload.word_class == LAST_CLASS)
      else $error("last mark on wrong class");

   // No new end-of-text item while counts still drain
   a_eot_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_payload.end_of_text && rsp_valid |-> req_stall)
      else $error("end-of-text taken while draining");

endmodule

bind keyword_class_word_counter kcwc_checker u_kcwc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
